### hw/rtl/q_table_select_and_update_core_macros.svh
// ----------------------------------------------------------------------------
// q_table_select_and_update_core assertion macros
// shared property shorthands for the q table core checks
// ----------------------------------------------------------------------------
`ifndef Q_TABLE_SELECT_AND_UPDATE_CORE_MACROS_SVH
`define Q_TABLE_SELECT_AND_UPDATE_CORE_MACROS_SVH

// same-cycle implication, quiet while in reset
`define QTSU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define QTSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/qtsu_pkg.sv
// ----------------------------------------------------------------------------
// qtsu_pkg
// shared constants, register codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qtsu_pkg;

  // default table geometry
  localparam int X_BINS_DEF  = 32;
  localparam int Y_BINS_DEF  = 32;
  localparam int ACTIONS_DEF = 4;

  // field widths
  localparam int COORD_W  = 5;
  localparam int ACTION_W = 2;
  localparam int PCT_W    = 7;
  localparam int Q_W      = 32;
  localparam int FRAC_W   = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 2'd2;

  localparam logic [PCT_W-1:0]  EPSILON_RST  = 7'd10;
  localparam logic [FRAC_W-1:0] LEARN_RST    = 16'd6554;
  localparam logic [FRAC_W-1:0] DISCOUNT_RST = 16'd58982;

  localparam logic OP_SELECT = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_wr;
    logic rd_seed;
    logic rd_scan;
    logic mul1;
    logic diff_en;
    logic mul2;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic op_upd;
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/qtsu_ctrl.sv
// ----------------------------------------------------------------------------
// qtsu_ctrl
// sequencer for table clearing, entry scans and the update arithmetic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qtsu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  qtsu_pkg::status_t status,
  output qtsu_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SEED,
    S_SCAN,
    S_DRAIN,
    S_MUL1,
    S_DIFF,
    S_MUL2,
    S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SEED;
            busy  <= 1'b1;
          end
        end
        S_CLEAR: begin
          if (status.clr_last) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_SEED: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (status.scan_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // last scan entry lands in the datapath during this cycle
          state <= status.op_upd ? S_MUL1 : S_FINISH;
        end
        S_MUL1: begin
          state <= S_DIFF;
        end
        S_DIFF: begin
          state <= S_MUL2;
        end
        S_MUL2: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.load    = start;
      S_CLEAR:  cmd.clr_wr  = 1'b1;
      S_SEED:   cmd.rd_seed = 1'b1;
      S_SCAN:   cmd.rd_scan = 1'b1;
      S_MUL1:   cmd.mul1    = 1'b1;
      S_DIFF:   cmd.diff_en = 1'b1;
      S_MUL2:   cmd.mul2    = 1'b1;
      S_FINISH: cmd.emit    = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/qtsu_datapath.sv
// ----------------------------------------------------------------------------
// qtsu_datapath
// q table memory, argmax/max scan, fixed-point update and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qtsu_datapath #(
  parameter int X_BINS  = qtsu_pkg::X_BINS_DEF,
  parameter int Y_BINS  = qtsu_pkg::Y_BINS_DEF,
  parameter int ACTIONS = qtsu_pkg::ACTIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  qtsu_pkg::cmd_t                    cmd,
  output qtsu_pkg::status_t                 status,
  input  logic                              op,
  input  logic [qtsu_pkg::COORD_W-1:0]      cur_x,
  input  logic [qtsu_pkg::COORD_W-1:0]      cur_y,
  input  logic [qtsu_pkg::COORD_W-1:0]      next_x,
  input  logic [qtsu_pkg::COORD_W-1:0]      next_y,
  input  logic [qtsu_pkg::ACTION_W-1:0]     action,
  input  logic signed [qtsu_pkg::Q_W-1:0]   reward,
  input  logic [qtsu_pkg::PCT_W-1:0]        rand_pct,
  input  logic [qtsu_pkg::ACTION_W-1:0]     rand_start_action,
  input  logic [qtsu_pkg::ACTION_W-1:0]     rand_explore_action,
  input  logic [qtsu_pkg::PCT_W-1:0]        epsilon_pct,
  input  logic [qtsu_pkg::FRAC_W-1:0]       learn_rate,
  input  logic [qtsu_pkg::FRAC_W-1:0]       discount,
  output logic [qtsu_pkg::ACTION_W-1:0]     chosen_action,
  output logic signed [qtsu_pkg::Q_W-1:0]   new_q,
  output logic                              explored
);

  localparam int DEPTH  = X_BINS * Y_BINS * ACTIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ACT_W  = $clog2(ACTIONS);

  // product and intermediate widths
  localparam int GM_W   = qtsu_pkg::FRAC_W + 1 + qtsu_pkg::Q_W;   // gamma * maxq
  localparam int GR_W   = GM_W - qtsu_pkg::FRAC_W;                // rounded
  localparam int DIFF_W = qtsu_pkg::Q_W + 3;
  localparam int BD_W   = qtsu_pkg::FRAC_W + 1 + DIFF_W;          // beta * diff
  localparam int BR_W   = BD_W - qtsu_pkg::FRAC_W;
  localparam int SUM_W  = BR_W + 1;

  localparam logic signed [GM_W-1:0] GM_HALF = GM_W'(32768);
  localparam logic signed [BD_W-1:0] BD_HALF = BD_W'(32768);

  function automatic logic [ACT_W-1:0] sat_act(input logic [qtsu_pkg::ACTION_W-1:0] a);
    if (int'(a) >= ACTIONS) begin
      return ACT_W'(ACTIONS - 1);
    end
    return ACT_W'(a);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_base(input logic [qtsu_pkg::COORD_W-1:0] x,
                                                  input logic [qtsu_pkg::COORD_W-1:0] y);
    int sx;
    int sy;
    sx = (int'(x) >= X_BINS) ? X_BINS - 1 : int'(x);
    sy = (int'(y) >= Y_BINS) ? Y_BINS - 1 : int'(y);
    return ADDR_W'((sx * Y_BINS + sy) * ACTIONS);
  endfunction

  logic signed [qtsu_pkg::Q_W-1:0] mem [DEPTH];
  logic signed [qtsu_pkg::Q_W-1:0] rd_data;
  logic [ADDR_W-1:0]               rd_addr;
  logic [ADDR_W-1:0]               wr_addr_mux;
  logic signed [qtsu_pkg::Q_W-1:0] wr_data_mux;
  logic                            wr_en;

  logic [ADDR_W-1:0]               clr_addr;
  logic [ADDR_W-1:0]               seed_addr;
  logic [ADDR_W-1:0]               scan_base;
  logic [ADDR_W-1:0]               upd_addr;
  logic [ACT_W-1:0]                idx;
  logic [ACT_W-1:0]                idx_d;
  logic                            seed_v;
  logic                            scan_v;

  logic                            op_r;
  logic                            explore_r;
  logic [ACT_W-1:0]                start_r;
  logic [ACT_W-1:0]                expl_act_r;
  logic signed [qtsu_pkg::Q_W-1:0] reward_r;

  logic signed [qtsu_pkg::Q_W-1:0] old_q;
  logic signed [qtsu_pkg::Q_W-1:0] best_q;
  logic [ACT_W-1:0]                best_idx;

  logic signed [GM_W-1:0]          gm_prod;
  logic signed [GM_W-1:0]          gm_sum;
  logic signed [GR_W-1:0]          gm_rnd;
  logic signed [DIFF_W-1:0]        diff;
  logic signed [DIFF_W-1:0]        diff_next;
  logic signed [BD_W-1:0]          bd_prod;
  logic signed [BD_W-1:0]          bd_sum;
  logic signed [BR_W-1:0]          bd_rnd;
  logic signed [SUM_W-1:0]         q_sum;
  logic signed [qtsu_pkg::Q_W-1:0] q_sat;

  assign status.clr_last  = (clr_addr == ADDR_W'(DEPTH - 1));
  assign status.scan_last = (idx == ACT_W'(ACTIONS - 1));
  assign status.op_upd    = (op_r == qtsu_pkg::OP_UPDATE);

  assign rd_addr     = cmd.rd_seed ? seed_addr : scan_base + ADDR_W'(idx);
  assign wr_en       = cmd.clr_wr | (cmd.emit & (op_r == qtsu_pkg::OP_UPDATE));
  assign wr_addr_mux = cmd.clr_wr ? clr_addr : upd_addr;
  assign wr_data_mux = cmd.clr_wr ? '0 : q_sat;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr_mux] <= wr_data_mux;
    end
    rd_data <= mem[rd_addr];
  end

  // clearing sweep and scan sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      idx      <= '0;
      seed_v   <= 1'b0;
      scan_v   <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.rd_scan && !status.scan_last) begin
        idx <= idx + 1'b1;
      end
      seed_v <= cmd.rd_seed;
      scan_v <= cmd.rd_scan;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= op;
      explore_r  <= (rand_pct <= epsilon_pct);
      start_r    <= sat_act(rand_start_action);
      expl_act_r <= sat_act(rand_explore_action);
      reward_r   <= reward;
      upd_addr   <= cell_base(cur_x, cur_y) + ADDR_W'(sat_act(action));
      if (op == qtsu_pkg::OP_UPDATE) begin
        seed_addr <= cell_base(cur_x, cur_y) + ADDR_W'(sat_act(action));
        scan_base <= cell_base(next_x, next_y);
      end else begin
        seed_addr <= cell_base(cur_x, cur_y) + ADDR_W'(sat_act(rand_start_action));
        scan_base <= cell_base(cur_x, cur_y);
      end
    end
    idx_d <= idx;
  end

  // seed entry first, then the scanned row (an update restarts from entry 0); strict compare keeps earlier winner
  always_ff @(posedge clk) begin
    if (seed_v) begin
      old_q    <= rd_data;
      best_q   <= rd_data;
      best_idx <= start_r;
    end else if (scan_v) begin
      if (rd_data > best_q || (op_r == qtsu_pkg::OP_UPDATE && idx_d == '0)) begin
        best_q   <= rd_data;
        best_idx <= idx_d;
      end
    end
  end

  assign gm_sum    = gm_prod + GM_HALF;
  assign gm_rnd    = gm_sum[GM_W-1:qtsu_pkg::FRAC_W];
  assign diff_next = DIFF_W'(reward_r) + DIFF_W'(gm_rnd) - DIFF_W'(old_q);

  assign bd_sum = bd_prod + BD_HALF;
  assign bd_rnd = bd_sum[BD_W-1:qtsu_pkg::FRAC_W];
  assign q_sum  = SUM_W'(old_q) + SUM_W'(bd_rnd);

  // saturate when the bits above the sign of a 32-bit word disagree
  always_comb begin
    if (q_sum[SUM_W-1:qtsu_pkg::Q_W-1] == '0 ||
        q_sum[SUM_W-1:qtsu_pkg::Q_W-1] == '1) begin
      q_sat = q_sum[qtsu_pkg::Q_W-1:0];
    end else if (q_sum[SUM_W-1]) begin
      q_sat = {1'b1, {(qtsu_pkg::Q_W-1){1'b0}}};
    end else begin
      q_sat = {1'b0, {(qtsu_pkg::Q_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      gm_prod <= $signed({1'b0, discount}) * best_q;
    end
    if (cmd.diff_en) begin
      diff <= diff_next;
    end
    if (cmd.mul2) begin
      bd_prod <= $signed({1'b0, learn_rate}) * diff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (op_r == qtsu_pkg::OP_UPDATE) begin
        chosen_action <= '0;
        explored      <= 1'b0;
        new_q         <= q_sat;
      end else begin
        chosen_action <= explore_r ? qtsu_pkg::ACTION_W'(expl_act_r)
                                   : qtsu_pkg::ACTION_W'(best_idx);
        explored      <= explore_r;
        new_q         <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/q_table_select_and_update_core.sv
// ----------------------------------------------------------------------------
// q_table_select_and_update_core
// tabular q learning: epsilon-greedy action choice and q entry update
// ----------------------------------------------------------------------------
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------
//   request  | start in, busy out        | op, cur/next coords, action,
//            |                           | reward, rand_pct, rand actions
//   result   | done out, one-cycle pulse | chosen_action, new_q, explored
//   config   | cfg_we in                 | cfg_index, cfg_data
//
// a select request reads its seed entry, scans the row one entry per cycle
// and drains; an update also runs the two registered multiplies, with the
// difference between them. busy stays high until the result is emitted.
// after reset the table is swept to zero, one entry a cycle, over all
// X_BINS*Y_BINS*ACTIONS entries (4096 by default) with busy held high.
// done pulses for one cycle in which a new request may already be accepted;
// the receiver cannot stall results.
//
`timescale 1ns / 1ps
`default_nettype none

module q_table_select_and_update_core #(
  parameter int X_BINS  = qtsu_pkg::X_BINS_DEF,
  parameter int Y_BINS  = qtsu_pkg::Y_BINS_DEF,
  parameter int ACTIONS = qtsu_pkg::ACTIONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  output logic                                done,
  input  logic                                op,
  input  logic [qtsu_pkg::COORD_W-1:0]        cur_x,
  input  logic [qtsu_pkg::COORD_W-1:0]        cur_y,
  input  logic [qtsu_pkg::COORD_W-1:0]        next_x,
  input  logic [qtsu_pkg::COORD_W-1:0]        next_y,
  input  logic [qtsu_pkg::ACTION_W-1:0]       action,
  input  logic signed [qtsu_pkg::Q_W-1:0]     reward,
  input  logic [qtsu_pkg::PCT_W-1:0]          rand_pct,
  input  logic [qtsu_pkg::ACTION_W-1:0]       rand_start_action,
  input  logic [qtsu_pkg::ACTION_W-1:0]       rand_explore_action,
  output logic [qtsu_pkg::ACTION_W-1:0]       chosen_action,
  output logic signed [qtsu_pkg::Q_W-1:0]     new_q,
  output logic                                explored,
  input  logic                                cfg_we,
  input  logic [qtsu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qtsu_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [qtsu_pkg::PCT_W-1:0]  epsilon_pct;
  logic [qtsu_pkg::FRAC_W-1:0] learn_rate;
  logic [qtsu_pkg::FRAC_W-1:0] discount;

  qtsu_pkg::cmd_t    cmd;
  qtsu_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon_pct <= qtsu_pkg::EPSILON_RST;
      learn_rate  <= qtsu_pkg::LEARN_RST;
      discount    <= qtsu_pkg::DISCOUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        qtsu_pkg::CFG_EPSILON:  epsilon_pct <= cfg_data[qtsu_pkg::PCT_W-1:0];
        qtsu_pkg::CFG_LEARN:    learn_rate  <= cfg_data[qtsu_pkg::FRAC_W-1:0];
        qtsu_pkg::CFG_DISCOUNT: discount    <= cfg_data[qtsu_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  qtsu_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  qtsu_datapath #(
    .X_BINS  (X_BINS),
    .Y_BINS  (Y_BINS),
    .ACTIONS (ACTIONS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .op                  (op),
    .cur_x               (cur_x),
    .cur_y               (cur_y),
    .next_x              (next_x),
    .next_y              (next_y),
    .action              (action),
    .reward              (reward),
    .rand_pct            (rand_pct),
    .rand_start_action   (rand_start_action),
    .rand_explore_action (rand_explore_action),
    .epsilon_pct         (epsilon_pct),
    .learn_rate          (learn_rate),
    .discount            (discount),
    .chosen_action       (chosen_action),
    .new_q               (new_q),
    .explored            (explored)
  );

`include "q_table_select_and_update_core_macros.svh"

  `QTSU_ASSERT_SAME(a_done_when_idle, clk, rst, done, !busy, "result while busy")
  `QTSU_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done, "request not taken")
  `QTSU_ASSERT_SAME(a_explore_no_q, clk, rst, done && explored, new_q == '0, "explore with q value")
  `QTSU_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result repeated")

endmodule

`default_nettype wire

### tb/qtsu_tb_pkg.sv
// ----------------------------------------------------------------------------
// qtsu_tb_pkg
// request and result types plus the scoreboard for the q table core bench:
// it mirrors the q table and registers and predicts each result as the
// request is accepted
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qtsu_tb_pkg;
  import qtsu_pkg::*;

  localparam longint Q_SAT_HI = 64'sd2147483647;
  localparam longint Q_SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic                       op;
    logic [COORD_W-1:0]         cur_x;
    logic [COORD_W-1:0]         cur_y;
    logic [COORD_W-1:0]         next_x;
    logic [COORD_W-1:0]         next_y;
    logic [ACTION_W-1:0]        action;
    logic signed [Q_W-1:0]      reward;
    logic [PCT_W-1:0]           rand_pct;
    logic [ACTION_W-1:0]        rand_start_action;
    logic [ACTION_W-1:0]        rand_explore_action;
  } q_request_t;

  typedef struct packed {
    logic [ACTION_W-1:0]        chosen_action;
    logic signed [Q_W-1:0]      new_q;
    logic                       explored;
  } q_result_t;

  class q_learn_scoreboard;
    logic signed [Q_W-1:0] q_mem [0:4095];
    logic [PCT_W-1:0]      epsilon;
    logic [FRAC_W-1:0]     beta;
    logic [FRAC_W-1:0]     gamma;
    q_result_t             pending_q[$];
    int errors;
    int n_select;
    int n_explored;
    int n_update;
    int n_saturated;
    int n_writes;

    function new();
      foreach (q_mem[i]) q_mem[i] = '0;
      epsilon     = EPSILON_RST;
      beta        = LEARN_RST;
      gamma       = DISCOUNT_RST;
      errors      = 0;
      n_select    = 0;
      n_explored  = 0;
      n_update    = 0;
      n_saturated = 0;
      n_writes    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      n_writes++;
      case (idx)
        CFG_EPSILON: begin
          epsilon = data[PCT_W-1:0];
        end
        CFG_LEARN: begin
          beta = data;
        end
        CFG_DISCOUNT: begin
          gamma = data;
        end
        default: begin
        end
      endcase
    endfunction

    // q0.16 times q16.16, rounded half up back to q16.16
    static function longint scale_q16(logic [FRAC_W-1:0] frac, longint v);
      longint f;
      f = frac;
      return (f * v + 64'sd32768) >>> 16;
    endfunction

    function void note_request(q_request_t r);
      q_result_t             res;
      logic [11:0]           cur_base;
      logic [11:0]           nxt;
      logic signed [Q_W-1:0] best;
      longint                old;
      longint                maxq;
      longint                diff;
      longint                sum;
      int                    a;
      res      = '0;
      cur_base = {r.cur_x, r.cur_y, 2'b00};
      if (r.op == OP_SELECT) begin
        n_select++;
        if (r.rand_pct <= epsilon) begin
          res.chosen_action = r.rand_explore_action;
          res.explored      = 1'b1;
          n_explored++;
        end else begin
          // strict greater-than, so ties stay on the random start action
          res.chosen_action = r.rand_start_action;
          best = q_mem[cur_base + r.rand_start_action];
          for (a = 0; a < ACTIONS_DEF; a++) begin
            if (q_mem[cur_base + a] > best) begin
              best = q_mem[cur_base + a];
              res.chosen_action = ACTION_W'(a);
            end
          end
        end
      end else begin
        n_update++;
        nxt  = {r.next_x, r.next_y, 2'b00};
        old  = q_mem[cur_base + r.action];
        maxq = q_mem[nxt];
        for (a = 1; a < ACTIONS_DEF; a++) begin
          if (q_mem[nxt + a] > maxq) maxq = q_mem[nxt + a];
        end
        diff = longint'($signed(r.reward)) + scale_q16(gamma, maxq) - old;
        sum  = old + scale_q16(beta, diff);
        if (sum > Q_SAT_HI) begin
          sum = Q_SAT_HI;
          n_saturated++;
        end else if (sum < Q_SAT_LO) begin
          sum = Q_SAT_LO;
          n_saturated++;
        end
        res.new_q = sum[Q_W-1:0];
        q_mem[cur_base + r.action] = sum[Q_W-1:0];
      end
      pending_q.push_back(res);
    endfunction

    function void check_result(logic [ACTION_W-1:0] chosen, logic signed [Q_W-1:0] q,
                               logic expl);
      q_result_t e;
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding: chosen_action %0d new_q %0d explored %0d",
               chosen, q, expl);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (chosen !== e.chosen_action) begin
        $error("chosen_action: expected %0d, got %0d", e.chosen_action, chosen);
        errors++;
      end
      if (q !== e.new_q) begin
        $error("new_q: expected %0d, got %0d", e.new_q, q);
        errors++;
      end
      if (expl !== e.explored) begin
        $error("explored: expected %0d, got %0d", e.explored, expl);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

endpackage

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// regression bench for q_table_select_and_update_core: directed corner
// requests, then random select/update traffic on a small pool of cells over
// several register settings, with random gaps; results checked by scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import qtsu_pkg::*;
  import qtsu_tb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  done;
  logic                  op = OP_SELECT;
  logic [COORD_W-1:0]    cur_x = '0;
  logic [COORD_W-1:0]    cur_y = '0;
  logic [COORD_W-1:0]    next_x = '0;
  logic [COORD_W-1:0]    next_y = '0;
  logic [ACTION_W-1:0]   action = '0;
  logic signed [Q_W-1:0] reward = '0;
  logic [PCT_W-1:0]      rand_pct = '0;
  logic [ACTION_W-1:0]   rand_start_action = '0;
  logic [ACTION_W-1:0]   rand_explore_action = '0;
  logic [ACTION_W-1:0]   chosen_action;
  logic signed [Q_W-1:0] new_q;
  logic                  explored;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  q_learn_scoreboard sb;
  int quiet_left = 0;

  q_table_select_and_update_core uut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .done                (done),
    .op                  (op),
    .cur_x               (cur_x),
    .cur_y               (cur_y),
    .next_x              (next_x),
    .next_y              (next_y),
    .action              (action),
    .reward              (reward),
    .rand_pct            (rand_pct),
    .rand_start_action   (rand_start_action),
    .rand_explore_action (rand_explore_action),
    .chosen_action       (chosen_action),
    .new_q               (new_q),
    .explored            (explored),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  // register writes, request acceptance and results all seen at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) begin
        sb.note_request('{op, cur_x, cur_y, next_x, next_y, action, reward, rand_pct,
                          rand_start_action, rand_explore_action});
      end
      if (done) sb.check_result(chosen_action, new_q, explored);
    end
  end

  function automatic q_request_t make_request(input logic o, input int cx, input int cy,
                                              input int nx, input int ny, input int act,
                                              input logic [Q_W-1:0] rew, input int pct,
                                              input int st, input int ex);
    q_request_t r;
    r.op                  = o;
    r.cur_x               = COORD_W'(cx);
    r.cur_y               = COORD_W'(cy);
    r.next_x              = COORD_W'(nx);
    r.next_y              = COORD_W'(ny);
    r.action              = ACTION_W'(act);
    r.reward              = rew;
    r.rand_pct            = PCT_W'(pct);
    r.rand_start_action   = ACTION_W'(st);
    r.rand_explore_action = ACTION_W'(ex);
    return r;
  endfunction

  // mostly a handful of cells so q values build up and argmax has work to do
  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(0, 9) < 7) return COORD_W'($urandom_range(0, 3));
    return COORD_W'($urandom_range(0, 31));
  endfunction

  function automatic q_request_t random_request();
    q_request_t r;
    r.op                  = ($urandom_range(0, 99) < 50) ? OP_UPDATE : OP_SELECT;
    r.cur_x               = pick_coord();
    r.cur_y               = pick_coord();
    r.next_x              = pick_coord();
    r.next_y              = pick_coord();
    r.action              = ACTION_W'($urandom_range(0, 3));
    r.rand_start_action   = ACTION_W'($urandom_range(0, 3));
    r.rand_explore_action = ACTION_W'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 85) r.rand_pct = PCT_W'($urandom_range(1, 100));
    else r.rand_pct = PCT_W'($urandom_range(0, 127));
    case ($urandom_range(0, 9))
      0: begin
        r.reward = $urandom;
      end
      1: begin
        case ($urandom_range(0, 3))
          0: r.reward = 32'h7FFF_FFFF;
          1: r.reward = 32'h8000_0000;
          2: r.reward = '0;
          default: r.reward = '1;
        endcase
      end
      2, 3, 4: begin
        r.reward = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      end
      default: begin
        r.reward = 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      end
    endcase
    return r;
  endfunction

  task automatic send_request(input q_request_t r);
    op                  <= r.op;
    cur_x               <= r.cur_x;
    cur_y               <= r.cur_y;
    next_x              <= r.next_x;
    next_y              <= r.next_y;
    action              <= r.action;
    reward              <= r.reward;
    rand_pct            <= r.rand_pct;
    rand_start_action   <= r.rand_start_action;
    rand_explore_action <= r.rand_explore_action;
    start               <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    int r;
    n = 0;
    if (quiet_left > 0) begin
      quiet_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) quiet_left = $urandom_range(10, 30);
      else if (r < 50) n = 0;
      else if (r < 85) n = $urandom_range(1, 3);
      else if (r < 97) n = $urandom_range(4, 10);
      else n = $urandom_range(20, 60);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_results();
    start <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic load_config(input logic [PCT_W-1:0] eps, input logic [FRAC_W-1:0] lr,
                             input logic [FRAC_W-1:0] disc);
    wait_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EPSILON;
    cfg_data  <= CFG_DATA_W'(eps);
    @(negedge clk);
    cfg_index <= CFG_LEARN;
    cfg_data  <= lr;
    @(negedge clk);
    cfg_index <= CFG_DISCOUNT;
    cfg_data  <= disc;
    @(negedge clk);
    // unmapped index, must leave every register alone
    cfg_index <= CFG_SPARE;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [PCT_W-1:0] eps, input logic [FRAC_W-1:0] lr,
                           input logic [FRAC_W-1:0] disc, input int n);
    int i;
    load_config(eps, lr, disc);
    for (i = 0; i < n; i++) begin
      if (i == n / 2) wait_results();
      send_request(random_request());
      idle_gap();
    end
  endtask

  task automatic send_directed(input q_request_t r);
    send_request(r);
    idle_gap();
  endtask

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    // table clear sweep after reset
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);

    // reset settings, table all zero
    send_directed(make_request(OP_SELECT, 0, 0, 0, 0, 0, 32'h0, 0, 1, 3));
    send_directed(make_request(OP_SELECT, 0, 0, 0, 0, 0, 32'h0, 10, 1, 2));
    send_directed(make_request(OP_SELECT, 0, 0, 0, 0, 0, 32'h0, 11, 3, 0));
    send_directed(make_request(OP_SELECT, 31, 31, 0, 0, 0, 32'h0, 127, 0, 1));
    send_directed(make_request(OP_UPDATE, 31, 31, 0, 0, 3, 32'h7FFF_FFFF, 50, 0, 0));
    // next cell equal to the current one
    send_directed(make_request(OP_UPDATE, 31, 31, 31, 31, 0, 32'h8000_0000, 50, 0, 0));
    send_directed(make_request(OP_UPDATE, 0, 0, 31, 31, 2, 32'h000A_0000, 50, 0, 0));
    send_directed(make_request(OP_SELECT, 31, 31, 0, 0, 0, 32'h0, 100, 0, 1));
    send_directed(make_request(OP_SELECT, 0, 0, 0, 0, 0, 32'h0, 50, 1, 0));
    send_directed(make_request(OP_UPDATE, 5, 7, 0, 0, 1, 32'hFFFF_0000, 50, 0, 0));
    send_directed(make_request(OP_SELECT, 5, 7, 0, 0, 0, 32'h0, 100, 1, 2));

    // full learning rate and discount push the sum into saturation
    load_config(7'd0, 16'hFFFF, 16'hFFFF);
    send_directed(make_request(OP_UPDATE, 31, 31, 31, 31, 3, 32'h7FFF_FFFF, 50, 0, 0));
    send_directed(make_request(OP_UPDATE, 31, 31, 31, 31, 3, 32'h7FFF_FFFF, 50, 0, 0));
    send_directed(make_request(OP_UPDATE, 31, 31, 16, 16, 0, 32'h8000_0000, 50, 0, 0));
    send_directed(make_request(OP_UPDATE, 1, 1, 31, 31, 1, 32'h0, 50, 0, 0));
    send_directed(make_request(OP_SELECT, 31, 31, 0, 0, 0, 32'h0, 1, 2, 0));
    send_directed(make_request(OP_SELECT, 1, 1, 0, 0, 0, 32'h0, 0, 2, 1));

    run_phase(7'd0, 16'hFFFF, 16'hFFFF, 120);
    run_phase(7'd100, 16'd0, 16'd0, 120);
    run_phase(7'd127, 16'h8000, 16'd0, 120);
    run_phase(7'd50, FRAC_W'($urandom), FRAC_W'($urandom), 120);
    run_phase(PCT_W'($urandom_range(0, 127)), FRAC_W'($urandom), FRAC_W'($urandom), 120);
    run_phase(7'd30, LEARN_RST, DISCOUNT_RST, 120);

    wait_results();
    repeat (16) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $error("%0d results never arrived", sb.outstanding());
      sb.errors++;
    end
    $display("covered %0d selects (%0d exploring) and %0d updates (%0d saturated)",
             sb.n_select, sb.n_explored, sb.n_update, sb.n_saturated);
    $display("%0d register writes over seven settings, boundary values included",
             sb.n_writes);
    if (sb.errors == 0) begin
      $display("q_table_select_and_update_core regression: pass");
    end else begin
      $display("q_table_select_and_update_core regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("q_table_select_and_update_core regression: fail");
    $finish;
  end

endmodule
